// ----- rtl/mevr_pkg.sv -----
// Package for the MIDI event voice router: widths, codes, config and RAM
// request structs, and the channel filter helper. No dependencies.

package mevr_pkg;

   // Sizes
   localparam int VOICE_BITS  = 16;
   localparam int KEY_COUNT   = 128;
   localparam int KEY_BITS    = $clog2(KEY_COUNT);
   localparam int VOICE_W     = 16;
   localparam int TAG_W       = 16;
   localparam int LEVEL_W     = 16;
   localparam int MAX_RESULTS = 4;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS);
   localparam int CSR_W       = 20;

   // Level scaling: v*LEVEL_MAX/AMT_MAX = v*LVL_SCALE + floor(v*LVL_REM/AMT_MAX)
   localparam int AMT_MAX     = 127;
   localparam int LEVEL_MAX   = 65535;
   localparam int LVL_SCALE   = LEVEL_MAX / AMT_MAX;
   localparam int LVL_REM     = LEVEL_MAX % AMT_MAX;
   localparam int AMT_PROD_W  = $clog2(AMT_MAX * LVL_REM + 1);
   localparam int AMT_FRAC_W  = $clog2(LVL_REM + 1);

   // Bend scaling: off*LEVEL_MAX/BEND_DIV = off*BEND_SCALE + floor(off*BEND_REM/BEND_DIV)
   localparam int BEND_W      = 14;
   localparam int BEND_OFF_MAX = 16383;
   localparam int BEND_DIV    = 16382;
   localparam int BEND_SCALE  = LEVEL_MAX / BEND_DIV;
   localparam int BEND_REM    = LEVEL_MAX % BEND_DIV;
   localparam int BEND_PROD_W = $clog2(BEND_OFF_MAX * BEND_REM + 1);
   localparam int BEND_FRAC_W = $clog2(BEND_REM + 1);
   localparam int BEND_SUM_W  = $clog2(BEND_OFF_MAX * BEND_SCALE + BEND_REM + 1);
   localparam logic [LEVEL_W-1:0] BEND_CENTER_LEVEL = 16'd32767;

   // Enable mask bits
   localparam int EN_NOTE  = 0;
   localparam int EN_VEL   = 1;
   localparam int EN_PITCH = 2;
   localparam int EN_CC    = 3;
   localparam int EN_BEND  = 4;
   localparam int EN_CHP   = 5;
   localparam int EN_KEYP  = 6;

   // Invert mask bits
   localparam int INV_CC   = 0;
   localparam int INV_CHP  = 1;
   localparam int INV_KEYP = 2;

   typedef enum logic [2:0] {
      OP_NOTE_ON    = 3'd0,
      OP_NOTE_OFF   = 3'd1,
      OP_CONTROLLER = 3'd2,
      OP_BEND       = 3'd3,
      OP_CHAN_PRESS = 3'd4,
      OP_KEY_PRESS  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_DROP        = 3'd0,
      KIND_CREATE      = 3'd1,
      KIND_VOICE_LEVEL = 3'd2,
      KIND_VOICE_PITCH = 3'd3,
      KIND_PLAIN_LEVEL = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CSR_ENABLE   = 3'd0,
      CSR_INVERT   = 3'd1,
      CSR_NOTE_CH  = 3'd2,
      CSR_OTHER_CH = 3'd3,
      CSR_CC_NUM   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [6:0]  enable_mask;
      logic [2:0]  invert_mask;
      logic [14:0] note_channels;
      logic [19:0] other_channels;
      logic [6:0]  cc_number;
   } cfg_type;

   typedef struct packed {
      logic                rd_en;
      logic [KEY_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [KEY_BITS-1:0] wr_addr;
      logic [VOICE_W-1:0]  wr_data;
   } ram_req_type;

   // Channel filter: 0 takes any channel, c takes channel c-1
   function automatic logic chan_ok(input logic [4:0] field, input logic [3:0] ch);
      return (field == 5'd0) || (field == ({1'b0, ch} + 5'd1));
   endfunction

endpackage

// ----- rtl/midi_event_voice_router.sv -----
// Top level of the MIDI event voice router: configuration registers, the
// per-key voice table RAM and the event sequencer.
// Depends on mevr_pkg, mevr_voice_ram and mevr_ctrl.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   request   req_op/channel/key/amount/bend/tag      start && !busy
//   result    rsp_kind/voice/note/level/last          rsp_valid, one cycle each
//   config    csr_index, csr_wdata                    csr_write_en, no wait
//
// An accepted item goes through the voice table lookup (registered RAM read,
// then read-modify-write of the key entry) and then sends one result per cycle,
// with busy high throughout; an item gives n = 0..4 results.
// A new item can be taken in the cycle after the final result.
// Reset (synchronous) empties the voice table at once through per-key valid
// bits, restarts voice ids at one and clears all configuration registers.
// Results cannot be held off by the receiver; each appears exactly once.

module midi_event_voice_router (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_op,
   input  logic [3:0]                         req_channel,
   input  logic [6:0]                         req_key,
   input  logic [6:0]                         req_amount,
   input  logic signed [mevr_pkg::BEND_W-1:0] req_bend,
   input  logic [mevr_pkg::TAG_W-1:0]         req_event_tag,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_kind,
   output logic [mevr_pkg::VOICE_W-1:0]       rsp_voice,
   output logic [6:0]                         rsp_note,
   output logic [mevr_pkg::LEVEL_W-1:0]       rsp_level,
   output logic                               rsp_last,
   input  logic                               csr_write_en,
   input  logic [2:0]                         csr_index,
   input  logic [mevr_pkg::CSR_W-1:0]         csr_wdata
);
   import mevr_pkg::*;

   cfg_type            cfg_ff;
   ram_req_type        ram_req;
   logic [VOICE_W-1:0] ram_rd_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLE:   cfg_ff.enable_mask    <= csr_wdata[6:0];
            CSR_INVERT:   cfg_ff.invert_mask    <= csr_wdata[2:0];
            CSR_NOTE_CH:  cfg_ff.note_channels  <= csr_wdata[14:0];
            CSR_OTHER_CH: cfg_ff.other_channels <= csr_wdata[19:0];
            CSR_CC_NUM:   cfg_ff.cc_number      <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   mevr_voice_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   mevr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_channel   (req_channel),
      .req_key       (req_key),
      .req_amount    (req_amount),
      .req_bend      (req_bend),
      .req_event_tag (req_event_tag),
      .cfg           (cfg_ff),
      .ram_req       (ram_req),
      .ram_rd_data   (ram_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_voice     (rsp_voice),
      .rsp_note      (rsp_note),
      .rsp_level     (rsp_level),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- rtl/mevr_voice_ram.sv -----
// Per-key voice table: 128 x 16 synchronous RAM, one read and one write port,
// registered read. Per-entry valid bits make unwritten keys read as no voice.
// Depends on mevr_pkg.

module mevr_voice_ram (
   input  logic                                clock,
   input  logic                                reset,
   input  mevr_pkg::ram_req_type               req,
   output logic [mevr_pkg::VOICE_W-1:0]        rd_data
);
   import mevr_pkg::*;

   logic [VOICE_W-1:0]   voice_mem [KEY_COUNT];
   logic [KEY_COUNT-1:0] valid_ff;
   logic [VOICE_W-1:0]   rd_data_ff;
   logic                 rd_valid_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         voice_mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= voice_mem[req.rd_addr];
      end
   end

   // Track written entries; reset empties the whole table at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/mevr_level_calc.sv -----
// Level scaling for one event: 7-bit value to 0.16 with optional inversion,
// and pitch bend to 0.16 with saturation, both by constant-division rewrite.
// Depends on mevr_pkg.

module mevr_level_calc (
   input  logic [2:0]                   op,
   input  logic [6:0]                   amount,
   input  logic signed [mevr_pkg::BEND_W-1:0] bend,
   input  logic [2:0]                   invert_mask,
   output logic [mevr_pkg::LEVEL_W-1:0] level
);
   import mevr_pkg::*;

   logic                   invert;
   logic [6:0]             amt_eff;
   logic [AMT_PROD_W-1:0]  amt_prod;
   logic [AMT_FRAC_W-1:0]  amt_frac;
   logic [LEVEL_W-1:0]     amt_level;
   logic [BEND_W-1:0]      bend_off;
   logic [BEND_PROD_W-1:0] bend_prod;
   logic [BEND_FRAC_W-1:0] bend_frac;
   logic [BEND_SUM_W-1:0]  bend_sum;
   logic [LEVEL_W-1:0]     bend_level;

   // Pick the inversion bit for this kind of event
   always_comb begin
      unique case (op)
         OP_CONTROLLER: invert = invert_mask[INV_CC];
         OP_CHAN_PRESS: invert = invert_mask[INV_CHP];
         OP_KEY_PRESS:  invert = invert_mask[INV_KEYP];
         default:       invert = 1'b0;
      endcase
   end

   // Scale a 7-bit value: integer part by constant, fraction by threshold count
   always_comb begin
      amt_eff  = invert ? (7'(AMT_MAX) - amount) : amount;
      amt_prod = AMT_PROD_W'(amt_eff) * AMT_PROD_W'(LVL_REM);
      amt_frac = '0;
      for (int k = 1; k <= LVL_REM; k++) begin
         if (amt_prod >= AMT_PROD_W'(k * AMT_MAX)) begin
            amt_frac = amt_frac + 1'b1;
         end
      end
      amt_level = LEVEL_W'(amt_eff * LVL_SCALE) + LEVEL_W'(amt_frac);
   end

   // Scale bend: offset to unsigned, then same rewrite, saturate at full scale; zero bend gives the center level
   always_comb begin
      bend_off  = {~bend[BEND_W-1], bend[BEND_W-2:0]};
      bend_prod = BEND_PROD_W'(bend_off) * BEND_PROD_W'(BEND_REM);
      bend_frac = '0;
      for (int k = 1; k <= BEND_REM; k++) begin
         if (bend_prod >= BEND_PROD_W'(k * BEND_DIV)) begin
            bend_frac = bend_frac + 1'b1;
         end
      end
      bend_sum = BEND_SUM_W'(bend_off * BEND_SCALE) + BEND_SUM_W'(bend_frac);
      if (bend == '0) begin
         bend_level = BEND_CENTER_LEVEL;
      end else if (bend_sum > BEND_SUM_W'(LEVEL_MAX)) begin
         bend_level = LEVEL_W'(LEVEL_MAX);
      end else begin
         bend_level = bend_sum[LEVEL_W-1:0];
      end
   end

   assign level = (op == OP_BEND) ? bend_level : amt_level;

endmodule

// ----- rtl/mevr_ctrl.sv -----
// Event sequencer: latches an item, reads the voice table, plans up to four
// results, writes the table back and sends the results one per cycle.
// Depends on mevr_pkg and mevr_level_calc.

module mevr_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_op,
   input  logic [3:0]                        req_channel,
   input  logic [6:0]                        req_key,
   input  logic [6:0]                        req_amount,
   input  logic signed [mevr_pkg::BEND_W-1:0] req_bend,
   input  logic [mevr_pkg::TAG_W-1:0]        req_event_tag,
   input  mevr_pkg::cfg_type                 cfg,
   output mevr_pkg::ram_req_type             ram_req,
   input  logic [mevr_pkg::VOICE_W-1:0]      ram_rd_data,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_kind,
   output logic [mevr_pkg::VOICE_W-1:0]      rsp_voice,
   output logic [6:0]                        rsp_note,
   output logic [mevr_pkg::LEVEL_W-1:0]      rsp_level,
   output logic                              rsp_last
);
   import mevr_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   // Latched item
   logic [2:0]          op_ff;
   logic [3:0]          chan_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [6:0]          amount_ff;
   logic signed [BEND_W-1:0] bend_ff;
   logic [TAG_W-1:0]    tag_ff;

   // Voice allocation state
   logic [VOICE_BITS-1:0] cur_voice_ff, cur_voice_in;
   logic [VOICE_BITS-1:0] next_voice_ff, next_voice_in;
   logic [TAG_W-1:0]      prior_tag_ff, prior_tag_in;
   logic                  prior_valid_ff, prior_valid_in;

   // Result queue
   kind_type           slot_kind_ff  [MAX_RESULTS];
   kind_type           slot_kind_in  [MAX_RESULTS];
   logic [VOICE_W-1:0] slot_voice_ff [MAX_RESULTS];
   logic [VOICE_W-1:0] slot_voice_in [MAX_RESULTS];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   // Planning
   logic                  cand_valid [MAX_RESULTS];
   kind_type              cand_kind  [MAX_RESULTS];
   logic [VOICE_W-1:0]    cand_voice [MAX_RESULTS];
   kind_type              plan_kind  [MAX_RESULTS];
   logic [VOICE_W-1:0]    plan_voice [MAX_RESULTS];
   logic [CNT_W-1:0]      plan_cnt;
   logic                  plan_wr;
   logic [VOICE_W-1:0]    plan_wr_data;
   logic                  tag_new;
   logic                  tbl_nz;
   logic [VOICE_BITS-1:0] voice_on;
   logic [VOICE_BITS-1:0] voice_inc;
   logic                  note_ok, vel_ok, pitch_ok, cc_ok, bend_ok, chp_ok, keyp_ok;
   logic [LEVEL_W-1:0]    calc_level;

   mevr_level_calc u_level (
      .op          (op_ff),
      .amount      (amount_ff),
      .bend        (bend_ff),
      .invert_mask (cfg.invert_mask),
      .level       (calc_level)
   );

   // Next state
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_LOOK : ST_IDLE;
         ST_LOOK: state_in = (plan_cnt == '0) ? ST_IDLE : ST_EMIT;
         ST_EMIT: state_in = (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      accept    = start && !busy;
   end

   // Table access: read on accept, write back during lookup
   always_comb begin
      ram_req.rd_en   = accept;
      ram_req.rd_addr = req_key;
      ram_req.wr_en   = (state_ff == ST_LOOK) && plan_wr;
      ram_req.wr_addr = key_ff;
      ram_req.wr_data = plan_wr_data;
   end

   // Filters
   always_comb begin
      note_ok  = cfg.enable_mask[EN_NOTE]  && chan_ok(cfg.note_channels[4:0], chan_ff);
      vel_ok   = cfg.enable_mask[EN_VEL]   && chan_ok(cfg.note_channels[9:5], chan_ff);
      pitch_ok = cfg.enable_mask[EN_PITCH] && chan_ok(cfg.note_channels[14:10], chan_ff);
      cc_ok    = cfg.enable_mask[EN_CC]    && chan_ok(cfg.other_channels[4:0], chan_ff)
                 && (key_ff == cfg.cc_number);
      bend_ok  = cfg.enable_mask[EN_BEND]  && chan_ok(cfg.other_channels[9:5], chan_ff);
      chp_ok   = cfg.enable_mask[EN_CHP]   && chan_ok(cfg.other_channels[14:10], chan_ff);
      keyp_ok  = cfg.enable_mask[EN_KEYP]  && chan_ok(cfg.other_channels[19:15], chan_ff);
   end

   // Plan the results and the state update from the table entry
   always_comb begin
      tbl_nz    = (ram_rd_data != '0);
      tag_new   = !prior_valid_ff || (prior_tag_ff != tag_ff);
      voice_inc = next_voice_ff + 1'b1;
      voice_on  = tag_new ? next_voice_ff : cur_voice_ff;

      cur_voice_in   = cur_voice_ff;
      next_voice_in  = next_voice_ff;
      prior_tag_in   = prior_tag_ff;
      prior_valid_in = prior_valid_ff;
      plan_wr        = 1'b0;
      plan_wr_data   = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         cand_valid[i] = 1'b0;
         cand_kind[i]  = KIND_DROP;
         cand_voice[i] = '0;
      end

      unique case (op_ff)
         OP_NOTE_ON: begin
            cur_voice_in = voice_on;
            if (tag_new) begin
               next_voice_in  = (voice_inc == '0) ? VOICE_BITS'(1) : voice_inc;
               prior_tag_in   = tag_ff;
               prior_valid_in = 1'b1;
            end
            if (note_ok) begin
               cand_valid[0] = tbl_nz;
               cand_kind[0]  = KIND_DROP;
               cand_voice[0] = ram_rd_data;
               cand_valid[1] = 1'b1;
               cand_kind[1]  = KIND_CREATE;
               cand_voice[1] = VOICE_W'(voice_on);
               plan_wr       = 1'b1;
               plan_wr_data  = VOICE_W'(voice_on);
            end
            cand_valid[2] = vel_ok;
            cand_kind[2]  = KIND_VOICE_LEVEL;
            cand_voice[2] = VOICE_W'(voice_on);
            cand_valid[3] = pitch_ok;
            cand_kind[3]  = KIND_VOICE_PITCH;
            cand_voice[3] = VOICE_W'(voice_on);
         end
         OP_NOTE_OFF: begin
            if (note_ok) begin
               cand_valid[0] = 1'b1;
               cand_kind[0]  = KIND_DROP;
               cand_voice[0] = ram_rd_data;
               cur_voice_in  = VOICE_BITS'(ram_rd_data);
               plan_wr       = 1'b1;
               plan_wr_data  = '0;
            end
            cand_valid[2] = vel_ok;
            cand_kind[2]  = KIND_VOICE_LEVEL;
            cand_voice[2] = VOICE_W'(cur_voice_in);
         end
         OP_CONTROLLER: begin
            cand_valid[0] = cc_ok;
            cand_kind[0]  = KIND_PLAIN_LEVEL;
         end
         OP_BEND: begin
            cand_valid[0] = bend_ok;
            cand_kind[0]  = KIND_PLAIN_LEVEL;
         end
         OP_CHAN_PRESS: begin
            cand_valid[0] = chp_ok;
            cand_kind[0]  = KIND_PLAIN_LEVEL;
         end
         OP_KEY_PRESS: begin
            cand_valid[0] = keyp_ok && tbl_nz;
            cand_kind[0]  = KIND_VOICE_LEVEL;
            cand_voice[0] = ram_rd_data;
         end
         default: begin
         end
      endcase

      // Pack the chosen results to the front of the queue
      plan_cnt = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         plan_kind[i]  = KIND_DROP;
         plan_voice[i] = '0;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (cand_valid[i]) begin
            plan_kind[plan_cnt[SLOT_IDX_W-1:0]]  = cand_kind[i];
            plan_voice[plan_cnt[SLOT_IDX_W-1:0]] = cand_voice[i];
            plan_cnt = plan_cnt + 1'b1;
         end
      end
   end

   // Load the queue after lookup, advance it on each sent result
   always_comb begin
      cnt_in   = cnt_ff;
      level_in = level_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_kind_in[i]  = slot_kind_ff[i];
         slot_voice_in[i] = slot_voice_ff[i];
      end
      if (state_ff == ST_LOOK) begin
         cnt_in   = plan_cnt;
         level_in = calc_level;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_kind_in[i]  = plan_kind[i];
            slot_voice_in[i] = plan_voice[i];
         end
      end else if (state_ff == ST_EMIT) begin
         cnt_in = cnt_ff - 1'b1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_kind_in[i]  = slot_kind_ff[i + 1];
            slot_voice_in[i] = slot_voice_ff[i + 1];
         end
         slot_kind_in[MAX_RESULTS-1]  = KIND_DROP;
         slot_voice_in[MAX_RESULTS-1] = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         cur_voice_ff   <= '0;
         next_voice_ff  <= VOICE_BITS'(1);
         prior_tag_ff   <= '0;
         prior_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == ST_LOOK) begin
            cur_voice_ff   <= cur_voice_in;
            next_voice_ff  <= next_voice_in;
            prior_tag_ff   <= prior_tag_in;
            prior_valid_ff <= prior_valid_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         chan_ff   <= req_channel;
         key_ff    <= req_key;
         amount_ff <= req_amount;
         bend_ff   <= req_bend;
         tag_ff    <= req_event_tag;
      end
      level_ff <= level_in;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_kind_ff[i]  <= slot_kind_in[i];
         slot_voice_ff[i] <= slot_voice_in[i];
      end
   end

   // Drive the head of the queue; unused fields read as zero
   always_comb begin
      rsp_kind  = slot_kind_ff[0];
      rsp_voice = slot_voice_ff[0];
      rsp_note  = (slot_kind_ff[0] == KIND_PLAIN_LEVEL) ? 7'd0 : key_ff;
      rsp_level = ((slot_kind_ff[0] == KIND_VOICE_LEVEL) ||
                   (slot_kind_ff[0] == KIND_PLAIN_LEVEL)) ? level_ff : '0;
      rsp_last  = rsp_valid && (cnt_ff == CNT_W'(1));
   end

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last flag without a result");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result queue count out of range");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff != '0))
      else $error("sending from an empty queue");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> (state_ff == ST_IDLE))
      else $error("still busy after the final result");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> $past(ram_req.rd_en))
      else $error("table write without its read");

endmodule
